FILE: rtl/q2e_pkg.sv
// Package for the quaternion to Euler angle converter: widths, constants,
// the arctangent table and shared types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

   localparam int QW      = 16;  // quaternion component width
   localparam int PW      = 32;  // product width
   localparam int ARGW    = 34;  // atan2 argument width
   localparam int CW      = 48;  // cordic datapath width
   localparam int ACCW    = 26;  // angle accumulator width, 1/32768 degree
   localparam int ITERS   = 20;
   localparam int NORM    = 40;  // normalize until a magnitude reaches 2^40
   localparam int SQW     = 58;  // square root datapath width
   localparam int SQSTEPS = 29;  // digit steps of the square root
   localparam int ATAN_LAT = ITERS + 4;

   localparam logic signed [ACCW-1:0] DEG180 = ACCW'(180 * 32768);
   localparam logic signed [15:0]     LIM180 = 16'sd23040;
   localparam logic signed [14:0]     LIM90  = 15'sd11520;

   typedef logic signed [ARGW-1:0] arg_type;

   // operands carried alongside the square root
   typedef struct packed {
      arg_type yaw_s;
      arg_type yaw_c;
      arg_type roll_s;
      arg_type roll_c;
      arg_type sp;
      logic    sat;
   } dly_type;

   // atan(2^-i) in 1/32768 degree
   function automatic logic signed [ACCW-1:0] atan_tab(input logic [4:0] i);
      logic signed [ACCW-1:0] v;
      unique case (i)
         5'd0:  v = 26'sd1474560;
         5'd1:  v = 26'sd870484;
         5'd2:  v = 26'sd459940;
         5'd3:  v = 26'sd233473;
         5'd4:  v = 26'sd117189;
         5'd5:  v = 26'sd58652;
         5'd6:  v = 26'sd29333;
         5'd7:  v = 26'sd14667;
         5'd8:  v = 26'sd7334;
         5'd9:  v = 26'sd3667;
         5'd10: v = 26'sd1833;
         5'd11: v = 26'sd917;
         5'd12: v = 26'sd458;
         5'd13: v = 26'sd229;
         5'd14: v = 26'sd115;
         5'd15: v = 26'sd57;
         5'd16: v = 26'sd29;
         5'd17: v = 26'sd14;
         5'd18: v = 26'sd7;
         5'd19: v = 26'sd4;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/q2e_if.sv
// Valid/ready channels for quaternion words in and Euler angle words out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface q2e_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;
   modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface q2e_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] yaw_angle;
   logic signed [14:0] pitch_angle;
   logic signed [15:0] roll_angle;
   modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
   modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface
`default_nettype wire

FILE: rtl/q2e_atan2.sv
// Pipelined atan2: quadrant fold, normalize, 20 cordic vectoring stages, round.
// Advances on en. Depends on q2e_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q2e_atan2 (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire q2e_pkg::arg_type      arg_s,
   input  wire q2e_pkg::arg_type      arg_c,
   output logic signed [15:0]         angle
);
   localparam int FW = q2e_pkg::ARGW + 1;
   localparam int CW = q2e_pkg::CW;
   localparam int AW = q2e_pkg::ACCW;
   localparam int N  = q2e_pkg::ITERS;

   // stage A: fold
   logic signed [FW-1:0] fs_ff, fc_ff, fs_in, fc_in;
   logic signed [AW-1:0] acca_ff, acca_in;
   logic [FW-1:0]        m_ff, m_in;
   logic                 za_ff, za_in;

   always_comb begin
      logic signed [FW-1:0] es, ec;
      es = FW'(arg_s);
      ec = FW'(arg_c);
      if (arg_c < 0) begin
         fs_in   = -es;
         fc_in   = -ec;
         acca_in = (arg_s >= 0) ? q2e_pkg::DEG180 : -q2e_pkg::DEG180;
      end else begin
         fs_in   = es;
         fc_in   = ec;
         acca_in = '0;
      end
      m_in  = ((fs_in < 0) ? FW'(-fs_in) : FW'(fs_in)) |
              ((fc_in < 0) ? FW'(-fc_in) : FW'(fc_in));
      za_in = (arg_s == '0) && (arg_c == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fs_ff <= fs_in; fc_ff <= fc_in; acca_ff <= acca_in;
         m_ff <= m_in; za_ff <= za_in;
      end
   end

   // stage B: leading one -> shift count
   logic signed [FW-1:0] fsb_ff, fcb_ff;
   logic signed [AW-1:0] accb_ff;
   logic                 zb_ff;
   logic [5:0]           k_ff, k_in;

   always_comb begin
      k_in = 6'(q2e_pkg::NORM);
      for (int b = 0; b < FW; b++) begin
         if (m_ff[b]) k_in = 6'(q2e_pkg::NORM - b);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fsb_ff <= fs_ff; fcb_ff <= fc_ff; accb_ff <= acca_ff;
         zb_ff <= za_ff; k_ff <= k_in;
      end
   end

   // stage C: normalize, then cordic stages
   logic signed [CW-1:0] s_ff [0:N];
   logic signed [CW-1:0] c_ff [0:N];
   logic signed [AW-1:0] acc_ff [0:N];
   logic                 z_ff [0:N];

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff[0]   <= CW'(fsb_ff) <<< k_ff;
         c_ff[0]   <= CW'(fcb_ff) <<< k_ff;
         acc_ff[0] <= accb_ff;
         z_ff[0]   <= zb_ff;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_cordic
      logic signed [CW-1:0] s_in, c_in;
      logic signed [AW-1:0] acc_in;
      always_comb begin
         if (s_ff[i] >= 0) begin
            c_in   = c_ff[i] + (s_ff[i] >>> i);
            s_in   = s_ff[i] - (c_ff[i] >>> i);
            acc_in = acc_ff[i] + q2e_pkg::atan_tab(5'(i));
         end else begin
            c_in   = c_ff[i] - (s_ff[i] >>> i);
            s_in   = s_ff[i] + (c_ff[i] >>> i);
            acc_in = acc_ff[i] - q2e_pkg::atan_tab(5'(i));
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[i+1] <= s_in; c_ff[i+1] <= c_in;
            acc_ff[i+1] <= acc_in; z_ff[i+1] <= z_ff[i];
         end
      end
   end

   // round to 1/128 degree, ties up, and clamp
   logic signed [15:0] angle_ff, angle_in;
   always_comb begin
      logic signed [AW-1:0] r;
      r = (acc_ff[N] + AW'(128)) >>> 8;
      if (z_ff[N])
         angle_in = '0;
      else if (r > AW'(q2e_pkg::LIM180))
         angle_in = q2e_pkg::LIM180;
      else if (r < -AW'(q2e_pkg::LIM180))
         angle_in = -q2e_pkg::LIM180;
      else
         angle_in = 16'(r);
   end

   always_ff @(posedge clock) begin
      if (en) angle_ff <= angle_in;
   end

   assign angle = angle_ff;
endmodule
`default_nettype wire

FILE: rtl/quaternion_to_euler_top.sv
// Quaternion to ZYX Euler angles converter, top level.
// Depends on q2e_pkg, q2e_if and q2e_atan2.
`timescale 1ns / 1ps
`default_nettype none
// Takes one Q2.14 quaternion word per cycle when not stalled and returns yaw,
// pitch and roll in 1/128 degree. Latency is set by the 29-step square root on
// the pitch path followed by the 24-stage atan2 pipeline; yaw and roll ride
// along in delay registers. A stalled output holds the whole pipeline, so the
// block takes a word whenever the output register is empty or being drained.
module quaternion_to_euler_top (
   input wire logic clock,
   input wire logic reset,
   q2e_req_if.sink  req,
   q2e_rsp_if.source rsp
);
   localparam int PW  = q2e_pkg::PW;
   localparam int AG  = q2e_pkg::ARGW;
   localparam int SW  = q2e_pkg::SQW;
   localparam int NS  = q2e_pkg::SQSTEPS;
   localparam int AL  = q2e_pkg::ATAN_LAT;
   localparam int NST = 3 + NS + AL + 1;

   logic en;
   logic [NST-1:0] vld_ff, vld_in;

   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;
   assign vld_in    = {vld_ff[NST-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= vld_in;
   end

   // stage 1: products
   logic signed [PW-1:0] wz_ff, xy_ff, yy_ff, zz_ff, wx_ff, yz_ff, xx_ff, wy_ff, zx_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         wz_ff <= req.quat_w * req.quat_z;
         xy_ff <= req.quat_x * req.quat_y;
         yy_ff <= req.quat_y * req.quat_y;
         zz_ff <= req.quat_z * req.quat_z;
         wx_ff <= req.quat_w * req.quat_x;
         yz_ff <= req.quat_y * req.quat_z;
         xx_ff <= req.quat_x * req.quat_x;
         wy_ff <= req.quat_w * req.quat_y;
         zx_ff <= req.quat_z * req.quat_x;
      end
   end

   // stage 2: atan2 arguments, pitch range check
   localparam logic signed [AG-1:0] ONE = AG'(1) <<< 28;
   q2e_pkg::dly_type d2_ff, d2_in;
   logic [27:0]      mag2_ff, mag2_in;

   always_comb begin
      d2_in.yaw_s  = (AG'(wz_ff) + AG'(xy_ff)) <<< 1;
      d2_in.yaw_c  = ONE - ((AG'(yy_ff) + AG'(zz_ff)) <<< 1);
      d2_in.roll_s = (AG'(wx_ff) + AG'(yz_ff)) <<< 1;
      d2_in.roll_c = ONE - ((AG'(xx_ff) + AG'(yy_ff)) <<< 1);
      d2_in.sp     = (AG'(wy_ff) - AG'(zx_ff)) <<< 1;
      d2_in.sat    = (d2_in.sp >= ONE) || (d2_in.sp <= -ONE);
      if (d2_in.sat)
         mag2_in = '0;
      else if (d2_in.sp < 0)
         mag2_in = 28'(-d2_in.sp);
      else
         mag2_in = 28'(d2_in.sp);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff <= d2_in; mag2_ff <= mag2_in;
      end
   end

   // stage 3: 2^56 - sp^2
   q2e_pkg::dly_type d3_ff;
   logic [SW-1:0]    rem3_ff, rem3_in;
   always_comb begin
      logic [55:0] sq;
      sq      = mag2_ff * mag2_ff;
      rem3_in = (SW'(1) << 56) - SW'(sq);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d3_ff <= d2_ff; rem3_ff <= rem3_in;
      end
   end

   // square root, one result bit per stage
   logic [SW-1:0]    v_ff  [0:NS];
   logic [SW-1:0]    r_ff  [0:NS];
   q2e_pkg::dly_type dq_ff [0:NS];

   assign v_ff[0]  = rem3_ff;
   assign r_ff[0]  = '0;
   assign dq_ff[0] = d3_ff;

   for (genvar j = 0; j < NS; j++) begin : g_sqrt
      localparam logic [SW-1:0] BIT = SW'(1) << (56 - 2 * j);
      logic [SW-1:0] v_in, r_in, t;
      always_comb begin
         t = r_ff[j] + BIT;
         if (v_ff[j] >= t) begin
            v_in = v_ff[j] - t;
            r_in = (r_ff[j] >> 1) + BIT;
         end else begin
            v_in = v_ff[j];
            r_in = r_ff[j] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[j+1] <= v_in; r_ff[j+1] <= r_in; dq_ff[j+1] <= dq_ff[j];
         end
      end
   end

   // three atan2 pipelines in lockstep
   logic signed [15:0] yaw_a, roll_a, pitch_a;

   q2e_atan2 u_yaw (
      .clock (clock), .en (en),
      .arg_s (dq_ff[NS].yaw_s), .arg_c (dq_ff[NS].yaw_c), .angle (yaw_a)
   );
   q2e_atan2 u_roll (
      .clock (clock), .en (en),
      .arg_s (dq_ff[NS].roll_s), .arg_c (dq_ff[NS].roll_c), .angle (roll_a)
   );
   q2e_atan2 u_pitch (
      .clock (clock), .en (en),
      .arg_s (dq_ff[NS].sp), .arg_c (AG'(r_ff[NS][28:0])), .angle (pitch_a)
   );

   // pitch saturation flag and sign follow the atan2 latency
   logic sat_ff [0:AL-1];
   logic neg_ff [0:AL-1];
   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff[0] <= dq_ff[NS].sat;
         neg_ff[0] <= dq_ff[NS].sp < 0;
         for (int a = 1; a < AL; a++) begin
            sat_ff[a] <= sat_ff[a-1];
            neg_ff[a] <= neg_ff[a-1];
         end
      end
   end

   // output register
   logic signed [15:0] yaw_ff, roll_ff;
   logic signed [14:0] pitch_ff, pitch_in;
   always_comb begin
      if (sat_ff[AL-1])
         pitch_in = neg_ff[AL-1] ? -q2e_pkg::LIM90 : q2e_pkg::LIM90;
      else if (pitch_a > 16'(q2e_pkg::LIM90))
         pitch_in = q2e_pkg::LIM90;
      else if (pitch_a < -16'(q2e_pkg::LIM90))
         pitch_in = -q2e_pkg::LIM90;
      else
         pitch_in = 15'(pitch_a);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yaw_ff <= yaw_a; roll_ff <= roll_a; pitch_ff <= pitch_in;
      end
   end

   assign rsp.valid       = vld_ff[NST-1];
   assign rsp.yaw_angle   = yaw_ff;
   assign rsp.roll_angle  = roll_ff;
   assign rsp.pitch_angle = pitch_ff;

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.pitch_angle <= q2e_pkg::LIM90) &&
                    (rsp.pitch_angle >= -q2e_pkg::LIM90))
      else $error("pitch out of range");
   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.yaw_angle <= q2e_pkg::LIM180) &&
                    (rsp.yaw_angle >= -q2e_pkg::LIM180))
      else $error("yaw out of range");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(vld_ff))
      else $error("pipeline moved during stall");
endmodule
`default_nettype wire
